// File: rtl/core/dfc_pkg.sv
// shared types and constants of the decision forest classifier
package dfc_pkg;

    localparam int IDX_W  = 11;
    localparam int THR_W  = 32;
    localparam int FEAT_W = 32;
    localparam int TNUM_W = 4;
    localparam int VOTE_W = 4;
    localparam int SEL_W  = 2;
    localparam int EXT_W  = 17;

    typedef enum logic [1:0] {
        CMD_NODE     = 2'd0,
        CMD_ROOT     = 2'd1,
        CMD_CLASSIFY = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    localparam logic [SEL_W-1:0] SEL_ZERO = 2'd0;
    localparam logic [SEL_W-1:0] SEL_ONE  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_TWO  = 2'd2;
    localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

    typedef struct packed {
        logic                     leaf;
        logic                     cls;
        logic [SEL_W-1:0]         feature;
        logic signed [THR_W-1:0]  threshold;
        logic [IDX_W-1:0]         left;
        logic [IDX_W-1:0]         right;
    } node_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [IDX_W-1:0]         node_index;
        logic                     is_leaf;
        logic                     leaf_class;
        logic [SEL_W-1:0]         split_feature;
        logic signed [THR_W-1:0]  split_threshold;
        logic [IDX_W-1:0]         left_child;
        logic [IDX_W-1:0]         right_child;
        logic [TNUM_W-1:0]        tree_number;
        logic signed [FEAT_W-1:0] feature_zero;
        logic signed [FEAT_W-1:0] feature_one;
        logic signed [FEAT_W-1:0] feature_two;
    } entry_t;

endpackage

// File: rtl/core/dfc_if.sv
// request and response channel interfaces
interface dfc_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [1:0]                               cmd;
    logic [dfc_pkg::IDX_W-1:0]                node_index;
    logic                                     is_leaf;
    logic                                     leaf_class;
    logic [dfc_pkg::SEL_W-1:0]                split_feature;
    logic signed [dfc_pkg::THR_W-1:0]         split_threshold;
    logic [dfc_pkg::IDX_W-1:0]                left_child;
    logic [dfc_pkg::IDX_W-1:0]                right_child;
    logic [dfc_pkg::TNUM_W-1:0]               tree_number;
    logic signed [dfc_pkg::FEAT_W-1:0]        feature_zero;
    logic signed [dfc_pkg::FEAT_W-1:0]        feature_one;
    logic signed [dfc_pkg::FEAT_W-1:0]        feature_two;

    modport source (
        output valid, cmd, node_index, is_leaf, leaf_class, split_feature,
               split_threshold, left_child, right_child, tree_number,
               feature_zero, feature_one, feature_two,
        input  ready
    );
    modport sink (
        input  valid, cmd, node_index, is_leaf, leaf_class, split_feature,
               split_threshold, left_child, right_child, tree_number,
               feature_zero, feature_one, feature_two,
        output ready
    );
endinterface

interface dfc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        majority_class;
    logic [dfc_pkg::VOTE_W-1:0]  votes_for_one;
    logic [dfc_pkg::VOTE_W-1:0]  votes_for_zero;
    logic                        walk_fault;

    modport source (
        output valid, majority_class, votes_for_one, votes_for_zero, walk_fault,
        input  ready
    );
    modport sink (
        input  valid, majority_class, votes_for_one, votes_for_zero, walk_fault,
        output ready
    );
endinterface

// File: rtl/core/decision_forest_classifier_top.sv
// classify: the back end walks each present tree from its root down to a leaf, node reads
// come from the single read port of the node ram at one per cycle, and the votes go to
// the result register once the last tree is done
// node write and root set retire as the queue head is popped in idle; a 2-entry queue decouples input
// reset clears tree present flags, the command queue and the result valid
// node table and tree roots are undefined until written
module decision_forest_classifier_top #(
    parameter int TREE_COUNT = 10,
    parameter int NODE_SLOTS = 2048,
    parameter int TREE_DEPTH = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    dfc_req_if.sink   req,
    dfc_rsp_if.source rsp
);

    logic            head_valid;
    logic            pop;
    dfc_pkg::entry_t head;

    dfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    dfc_back #(
        .TREE_COUNT (TREE_COUNT),
        .NODE_SLOTS (NODE_SLOTS),
        .TREE_DEPTH (TREE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

// File: rtl/core/dfc_ram.sv
// generic single-port-write, single-port-read ram with registered read
module dfc_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/dfc_front.sv
// front end: accepts transactions, drops CMD_NONE commands, queues the rest
module dfc_front (
    input  logic            clk,
    input  logic            rst_n,
    dfc_req_if.sink         req,
    input  logic            pop,
    output logic            head_valid,
    output dfc_pkg::entry_t head
);

    localparam int QDEPTH = 2;

    dfc_pkg::entry_t queue_reg [QDEPTH];
    dfc_pkg::entry_t entry_in;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic            accept;
    logic            push;

    always_comb
    begin
        entry_in.cmd             = dfc_pkg::cmd_t'(req.cmd);
        entry_in.node_index      = req.node_index;
        entry_in.is_leaf         = req.is_leaf;
        entry_in.leaf_class      = req.leaf_class;
        entry_in.split_feature   = req.split_feature;
        entry_in.split_threshold = req.split_threshold;
        entry_in.left_child      = req.left_child;
        entry_in.right_child     = req.right_child;
        entry_in.tree_number     = req.tree_number;
        entry_in.feature_zero    = req.feature_zero;
        entry_in.feature_one     = req.feature_one;
        entry_in.feature_two     = req.feature_two;
    end

    assign req.ready  = (count_reg != 2'(QDEPTH));
    assign accept     = req.valid && req.ready;
    assign push       = accept && (entry_in.cmd != dfc_pkg::CMD_NONE);
    assign head_valid = (count_reg != 2'd0);
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// File: rtl/core/dfc_back.sv
// back end: node table, tree roots, tree walker and result register
module dfc_back #(
    parameter int TREE_COUNT = 10,
    parameter int NODE_SLOTS = 2048,
    parameter int TREE_DEPTH = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  dfc_pkg::entry_t head,
    output logic            pop,
    dfc_rsp_if.source       rsp
);

    localparam int AW = $clog2(NODE_SLOTS);
    localparam int TW = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1;
    localparam int DW = $clog2(TREE_DEPTH + 1);
    localparam int CW = $clog2(TREE_COUNT + 1);
    localparam int NW = $bits(dfc_pkg::node_t);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TREE = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [TW-1:0]                    tree_reg, tree_next;
    logic [DW-1:0]                    depth_reg, depth_next;
    logic [CW-1:0]                    ones_reg, ones_next;
    logic [CW-1:0]                    zeros_reg, zeros_next;
    logic                             fault_reg, fault_next;
    logic                             oob_reg, oob_next;
    logic [TREE_COUNT-1:0]            present_reg;
    logic [dfc_pkg::IDX_W-1:0]        roots_reg [TREE_COUNT];
    logic signed [dfc_pkg::FEAT_W-1:0] feat0_reg, feat1_reg, feat2_reg;

    logic                             rsp_valid_reg;
    logic                             class_reg;
    logic [dfc_pkg::VOTE_W-1:0]       vote1_reg;
    logic [dfc_pkg::VOTE_W-1:0]       vote0_reg;
    logic                             rfault_reg;

    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic                             ram_re;
    logic [AW-1:0]                    ram_raddr;
    logic [NW-1:0]                    ram_rdata;
    dfc_pkg::node_t                   wnode;
    dfc_pkg::node_t                   node;
    logic [dfc_pkg::EXT_W-1:0]        wr_ext;
    logic [dfc_pkg::EXT_W-1:0]        rd_ext;
    logic [dfc_pkg::IDX_W-1:0]        rd_idx;
    logic signed [dfc_pkg::FEAT_W-1:0] xval;
    logic [dfc_pkg::IDX_W-1:0]        child;
    logic                             out_free;
    logic                             load;
    logic                             advance;
    logic                             root_ok;
    logic [4:0]                       ones_wide;
    logic [4:0]                       zeros_wide;

    // node table
    assign wr_ext    = {{(dfc_pkg::EXT_W - dfc_pkg::IDX_W){1'b0}}, head.node_index};
    assign ram_waddr = wr_ext[AW-1:0];
    assign ram_we    = pop && (head.cmd == dfc_pkg::CMD_NODE)
                       && (wr_ext < dfc_pkg::EXT_W'(NODE_SLOTS));

    always_comb
    begin
        wnode.leaf      = head.is_leaf;
        wnode.cls       = head.leaf_class;
        wnode.feature   = head.split_feature;
        wnode.threshold = head.split_threshold;
        wnode.left      = head.left_child;
        wnode.right     = head.right_child;
    end

    dfc_ram #(
        .WIDTH (NW),
        .DEPTH (NODE_SLOTS)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wnode),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // out-of-table reads give the all-zero node
    assign node = oob_reg ? dfc_pkg::node_t'('0) : dfc_pkg::node_t'(ram_rdata);

    always_comb
    begin
        case (node.feature)
            dfc_pkg::SEL_ZERO: xval = feat0_reg;
            dfc_pkg::SEL_ONE:  xval = feat1_reg;
            dfc_pkg::SEL_TWO:  xval = feat2_reg;
            default:           xval = '0;
        endcase
    end

    assign child     = (xval < node.threshold) ? node.left : node.right;
    assign rd_ext    = {{(dfc_pkg::EXT_W - dfc_pkg::IDX_W){1'b0}}, rd_idx};
    assign ram_raddr = rd_ext[AW-1:0];
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign root_ok   = ({1'b0, head.tree_number} < 5'(TREE_COUNT));

    always_comb
    begin
        state_next = state_reg;
        tree_next  = tree_reg;
        depth_next = depth_reg;
        ones_next  = ones_reg;
        zeros_next = zeros_reg;
        fault_next = fault_reg;
        pop        = 1'b0;
        ram_re     = 1'b0;
        rd_idx     = roots_reg[tree_reg];
        load       = 1'b0;
        advance    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.cmd == dfc_pkg::CMD_CLASSIFY)
                    begin
                        tree_next  = '0;
                        ones_next  = '0;
                        zeros_next = '0;
                        fault_next = 1'b0;
                        state_next = ST_TREE;
                    end
                end
            end
            ST_TREE:
            begin
                if (present_reg[tree_reg])
                begin
                    ram_re     = 1'b1;
                    depth_next = '0;
                    state_next = ST_WALK;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (node.leaf)
                begin
                    if (node.cls)
                    begin
                        ones_next = ones_reg + CW'(1);
                    end
                    else
                    begin
                        zeros_next = zeros_reg + CW'(1);
                    end
                    advance = 1'b1;
                end
                else if (depth_reg == DW'(TREE_DEPTH))
                begin
                    fault_next = 1'b1;
                    advance    = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    rd_idx     = child;
                    depth_next = depth_reg + DW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (advance)
        begin
            if (tree_reg == TW'(TREE_COUNT - 1))
            begin
                state_next = ST_DONE;
            end
            else
            begin
                tree_next  = tree_reg + TW'(1);
                state_next = ST_TREE;
            end
        end
    end

    assign oob_next   = ram_re ? !(rd_ext < dfc_pkg::EXT_W'(NODE_SLOTS)) : oob_reg;
    assign ones_wide  = 5'(ones_reg);
    assign zeros_wide = 5'(zeros_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tree_reg      <= '0;
            depth_reg     <= '0;
            ones_reg      <= '0;
            zeros_reg     <= '0;
            fault_reg     <= 1'b0;
            oob_reg       <= 1'b0;
            present_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tree_reg  <= tree_next;
            depth_reg <= depth_next;
            ones_reg  <= ones_next;
            zeros_reg <= zeros_next;
            fault_reg <= fault_next;
            oob_reg   <= oob_next;
            if (pop && (head.cmd == dfc_pkg::CMD_ROOT) && root_ok)
            begin
                present_reg[head.tree_number[TW-1:0]] <= 1'b1;
            end
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (head.cmd == dfc_pkg::CMD_ROOT) && root_ok)
        begin
            roots_reg[head.tree_number[TW-1:0]] <= head.node_index;
        end
        if (pop && (head.cmd == dfc_pkg::CMD_CLASSIFY))
        begin
            feat0_reg <= head.feature_zero;
            feat1_reg <= head.feature_one;
            feat2_reg <= head.feature_two;
        end
        if (load)
        begin
            class_reg  <= (ones_reg > zeros_reg);
            vote1_reg  <= (ones_wide > 5'd15) ? 4'd15 : ones_wide[3:0];
            vote0_reg  <= (zeros_wide > 5'd15) ? 4'd15 : zeros_wide[3:0];
            rfault_reg <= fault_reg;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.majority_class = class_reg;
    assign rsp.votes_for_one  = vote1_reg;
    assign rsp.votes_for_zero = vote0_reg;
    assign rsp.walk_fault     = rfault_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE) && head_valid)
        else $error("queue popped outside idle");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (depth_reg <= DW'(TREE_DEPTH)))
        else $error("walk depth beyond bound");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && !out_free |=> (state_reg == ST_DONE))
        else $error("result lost while output busy");

    a_vote_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ((6'(ones_reg) + 6'(zeros_reg)) <= 6'(TREE_COUNT)))
        else $error("more votes than trees");

endmodule
